// File: hdl/kst_pkg.sv
package kst_pkg;

	localparam int KEY_COUNT_DEF = 256;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAPTURE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONTROL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALT      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SNAPSHOT = 3'd4;

	localparam logic       CAPTURE_RST  = 1'b0;
	localparam logic [7:0] SHIFT_RST    = 8'd16;
	localparam logic [7:0] CONTROL_RST  = 8'd17;
	localparam logic [7:0] ALT_RST      = 8'd18;
	localparam logic [7:0] SNAPSHOT_RST = 8'd44;

	// Request opcodes
	localparam logic [1:0] OP_EVENT  = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_RELALL = 2'd2;
	localparam logic [1:0] OP_QUERY  = 2'd3;

	// Key states; bit 1 marks a held key
	localparam logic [1:0] ST_UP       = 2'd0;
	localparam logic [1:0] ST_RELEASED = 2'd1;
	localparam logic [1:0] ST_DOWN     = 2'd2;
	localparam logic [1:0] ST_PRESSED  = 2'd3;
	localparam int         HELD_BIT    = 1;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] key_code;
		logic       key_down;
	} req_t;

	typedef struct packed {
		logic [1:0] key_state;
		logic       key_repeat;
		logic [2:0] modifier_mask;
		logic       captured;
	} rsp_t;

	typedef enum logic [1:0] {
		RS_KEY   = 2'd0,
		RS_SHIFT = 2'd1,
		RS_CTRL  = 2'd2,
		RS_ALT   = 2'd3
	} rpt_sel_t;

	typedef struct packed {
		logic     load;
		logic     clear_wr;
		logic     ev_rd;
		logic     ev_wr;
		logic     sweep_rd;
		logic     rpt_rd;
		rpt_sel_t rpt_sel;
	} cmd_t;

	typedef struct packed {
		logic last_idx;
		logic ev_apply;
		logic sweep;
	} status_t;

endpackage

// File: hdl/key_state_tracker_top.sv
// Keyboard key state tracker.
// Requests arrive on the req channel (valid/ready): a key event, a frame tick,
// a release-all or a query. Each request yields exactly one response on the
// rsp channel (valid/ready) with the addressed key's state and repeat flag,
// the shift/control/alt mask and the capture flag.
// The per-key state lives in a table with one read port and one write port.
// A query reads the addressed key and then the modifier keys before the response
// is given; an applied key event first reads and writes back its entry, and
// a frame tick or release-all first walks the table one entry per cycle. The
// modifier mask comes from three further table reads after the addressed key.
// One request is in flight at a time; req_ready is high only while idle, so
// with a ready receiver the next request is taken in the idle state that
// follows the response transfer.
// If the receiver stalls, the response is held and no new request is taken.
// After reset the table is cleared one entry per cycle with req_ready low;
// configuration writes are taken at any time, but should only be issued while
// no request is in flight.
module key_state_tracker_top #(
	parameter int KEY_COUNT = kst_pkg::KEY_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [kst_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [kst_pkg::CFG_DATA_W-1:0]  wr_data,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  kst_pkg::req_t                   req,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output kst_pkg::rsp_t                   rsp
);

	kst_pkg::cmd_t    cmd;
	kst_pkg::status_t status;

	kst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.cmd       (cmd)
	);

	kst_dp #(
		.KEY_COUNT (KEY_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.req      (req),
		.cmd      (cmd),
		.status   (status),
		.rsp      (rsp)
	);

`ifndef NO_ASSERTIONS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("request taken while a response is pending");

	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !rsp_valid)
		else $error("response valid right after request transfer");

	a_ev_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ev_wr |-> $past(cmd.ev_rd))
		else $error("event write without preceding read");

	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ready) |=> req_ready)
		else $error("not ready after response transfer");
`endif

endmodule

// File: hdl/kst_ctrl.sv
module kst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  kst_pkg::status_t   status,
	output kst_pkg::cmd_t      cmd
);

	typedef enum logic [11:0] {
		C_CLEAR     = 12'b0000_0000_0001,
		C_IDLE      = 12'b0000_0000_0010,
		C_EV_RD     = 12'b0000_0000_0100,
		C_EV_WR     = 12'b0000_0000_1000,
		C_SWEEP     = 12'b0000_0001_0000,
		C_SWEEP_END = 12'b0000_0010_0000,
		C_RD_KEY    = 12'b0000_0100_0000,
		C_RD_SHIFT  = 12'b0000_1000_0000,
		C_RD_CTRL   = 12'b0001_0000_0000,
		C_RD_ALT    = 12'b0010_0000_0000,
		C_FIN       = 12'b0100_0000_0000,
		C_OUT       = 12'b1000_0000_0000
	} ctl_state_t;

	ctl_state_t state_q;
	ctl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		cmd         = '0;
		cmd.rpt_sel = kst_pkg::RS_KEY;
		req_ready   = 1'b0;
		rsp_valid   = 1'b0;
		unique case (state_q)
			C_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.last_idx) begin
					state_nxt = C_IDLE;
				end
			end
			C_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					if (status.ev_apply) begin
						state_nxt = C_EV_RD;
					end else if (status.sweep) begin
						state_nxt = C_SWEEP;
					end else begin
						state_nxt = C_RD_KEY;
					end
				end
			end
			C_EV_RD: begin
				cmd.ev_rd = 1'b1;
				state_nxt = C_EV_WR;
			end
			C_EV_WR: begin
				cmd.ev_wr = 1'b1;
				state_nxt = C_RD_KEY;
			end
			C_SWEEP: begin
				cmd.sweep_rd = 1'b1;
				if (status.last_idx) begin
					state_nxt = C_SWEEP_END;
				end
			end
			// The last entry of the sweep is written back here.
			C_SWEEP_END: begin
				state_nxt = C_RD_KEY;
			end
			C_RD_KEY: begin
				cmd.rpt_rd  = 1'b1;
				cmd.rpt_sel = kst_pkg::RS_KEY;
				state_nxt   = C_RD_SHIFT;
			end
			C_RD_SHIFT: begin
				cmd.rpt_rd  = 1'b1;
				cmd.rpt_sel = kst_pkg::RS_SHIFT;
				state_nxt   = C_RD_CTRL;
			end
			C_RD_CTRL: begin
				cmd.rpt_rd  = 1'b1;
				cmd.rpt_sel = kst_pkg::RS_CTRL;
				state_nxt   = C_RD_ALT;
			end
			C_RD_ALT: begin
				cmd.rpt_rd  = 1'b1;
				cmd.rpt_sel = kst_pkg::RS_ALT;
				state_nxt   = C_FIN;
			end
			C_FIN: begin
				state_nxt = C_OUT;
			end
			C_OUT: begin
				rsp_valid = 1'b1;
				if (rsp_ready) begin
					state_nxt = C_IDLE;
				end
			end
			default: begin
				state_nxt = C_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/kst_dp.sv
module kst_dp #(
	parameter int KEY_COUNT = kst_pkg::KEY_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [kst_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [kst_pkg::CFG_DATA_W-1:0]   wr_data,
	input  kst_pkg::req_t                    req,
	input  kst_pkg::cmd_t                    cmd,
	output kst_pkg::status_t                 status,
	output kst_pkg::rsp_t                    rsp
);

	localparam int IW = $clog2(KEY_COUNT);
	localparam int CW = ((IW > 8) ? IW : 8) + 1;

	typedef struct packed {
		logic [1:0] state;
		logic       rpt;
		logic       pend;
	} entry_t;

	// Configuration registers
	logic       capture_q;
	logic [7:0] shift_q;
	logic [7:0] control_q;
	logic [7:0] alt_q;
	logic [7:0] snap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_q <= kst_pkg::CAPTURE_RST;
			shift_q   <= kst_pkg::SHIFT_RST;
			control_q <= kst_pkg::CONTROL_RST;
			alt_q     <= kst_pkg::ALT_RST;
			snap_q    <= kst_pkg::SNAPSHOT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				kst_pkg::REG_CAPTURE:  capture_q <= wr_data[0];
				kst_pkg::REG_SHIFT:    shift_q   <= wr_data;
				kst_pkg::REG_CONTROL:  control_q <= wr_data;
				kst_pkg::REG_ALT:      alt_q     <= wr_data;
				kst_pkg::REG_SNAPSHOT: snap_q    <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// Key codes widened so they can be compared against the key count.
	logic [CW-1:0] in_ext;
	logic [CW-1:0] key_ext;
	logic [CW-1:0] shift_ext;
	logic [CW-1:0] ctrl_ext;
	logic [CW-1:0] alt_ext;
	logic [CW-1:0] snap_ext;
	logic [CW-1:0] count_ext;

	kst_pkg::req_t req_q;

	assign count_ext = CW'(KEY_COUNT);
	assign in_ext    = CW'(req.key_code);
	assign key_ext   = CW'(req_q.key_code);
	assign shift_ext = CW'(shift_q);
	assign ctrl_ext  = CW'(control_q);
	assign alt_ext   = CW'(alt_q);
	assign snap_ext  = CW'(snap_q);

	// Sweep and clear index
	logic [IW-1:0] idx_q;
	logic          idx_last;

	assign idx_last = (idx_q == IW'(KEY_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.clear_wr || cmd.sweep_rd) begin
			idx_q <= idx_last ? '0 : idx_q + 1'b1;
		end
	end

	assign status.last_idx = idx_last;
	assign status.ev_apply = (req.opcode == kst_pkg::OP_EVENT) && !capture_q &&
		(in_ext < count_ext);
	assign status.sweep = (req.opcode == kst_pkg::OP_TICK) ||
		(req.opcode == kst_pkg::OP_RELALL);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	// Sweep read pipeline: the entry read in one cycle is written back in the next.
	logic                sweep_v_s1;
	logic [IW-1:0]       addr_s1;
	logic                rpt_v_s1;
	kst_pkg::rpt_sel_t   rpt_sel_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_v_s1 <= 1'b0;
			rpt_v_s1   <= 1'b0;
		end else begin
			sweep_v_s1 <= cmd.sweep_rd;
			rpt_v_s1   <= cmd.rpt_rd;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1    <= idx_q;
		rpt_sel_s1 <= cmd.rpt_sel;
	end

	// Key table
	entry_t        mem [KEY_COUNT];
	entry_t        rd_q;
	logic [IW-1:0] raddr;
	logic [IW-1:0] waddr;
	logic          mem_we;
	entry_t        wdata;
	entry_t        ev_next;
	entry_t        sw_next;
	logic [CW-1:0] addr_s1_ext;

	assign addr_s1_ext = CW'(addr_s1);

	always_comb begin
		ev_next = rd_q;
		if (req_q.key_code == snap_q) begin
			ev_next.state = kst_pkg::ST_PRESSED;
		end else if (req_q.key_down) begin
			if (rd_q.state == kst_pkg::ST_UP || rd_q.state == kst_pkg::ST_RELEASED) begin
				ev_next.state = kst_pkg::ST_PRESSED;
			end
			ev_next.rpt = 1'b1;
		end else if (rd_q.state == kst_pkg::ST_PRESSED) begin
			ev_next.pend = 1'b1;
		end else if (rd_q.state == kst_pkg::ST_DOWN) begin
			ev_next.state = kst_pkg::ST_RELEASED;
		end
	end

	always_comb begin
		sw_next      = rd_q;
		sw_next.pend = 1'b0;
		if (req_q.opcode == kst_pkg::OP_TICK) begin
			// Pressed settles to down, released to up.
			sw_next.state = {rd_q.state[1], 1'b0};
			sw_next.rpt   = 1'b0;
			if ((addr_s1_ext == snap_ext && rd_q.state == kst_pkg::ST_PRESSED) ||
				rd_q.pend) begin
				sw_next.state = kst_pkg::ST_RELEASED;
			end
		end else if (rd_q.state[kst_pkg::HELD_BIT]) begin
			sw_next.state = kst_pkg::ST_RELEASED;
		end
	end

	always_comb begin
		raddr = key_ext[IW-1:0];
		if (cmd.sweep_rd) begin
			raddr = idx_q;
		end else if (cmd.rpt_rd) begin
			case (cmd.rpt_sel)
				kst_pkg::RS_SHIFT: raddr = shift_ext[IW-1:0];
				kst_pkg::RS_CTRL:  raddr = ctrl_ext[IW-1:0];
				kst_pkg::RS_ALT:   raddr = alt_ext[IW-1:0];
				default:           raddr = key_ext[IW-1:0];
			endcase
		end
	end

	always_comb begin
		mem_we = 1'b0;
		waddr  = idx_q;
		wdata  = '0;
		if (cmd.clear_wr) begin
			mem_we = 1'b1;
		end else if (cmd.ev_wr) begin
			mem_we = 1'b1;
			waddr  = key_ext[IW-1:0];
			wdata  = ev_next;
		end else if (sweep_v_s1) begin
			mem_we = 1'b1;
			waddr  = addr_s1;
			wdata  = sw_next;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	// Result register
	kst_pkg::rsp_t rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q.captured <= (req.opcode == kst_pkg::OP_EVENT) && capture_q &&
				req.key_down;
		end
		if (rpt_v_s1) begin
			case (rpt_sel_s1)
				kst_pkg::RS_KEY: begin
					rsp_q.key_state  <= (key_ext < count_ext) ? rd_q.state : kst_pkg::ST_UP;
					rsp_q.key_repeat <= (key_ext < count_ext) && rd_q.rpt;
				end
				kst_pkg::RS_SHIFT: begin
					rsp_q.modifier_mask[0] <= (shift_ext < count_ext) &&
						rd_q.state[kst_pkg::HELD_BIT];
				end
				kst_pkg::RS_CTRL: begin
					rsp_q.modifier_mask[1] <= (ctrl_ext < count_ext) &&
						rd_q.state[kst_pkg::HELD_BIT];
				end
				default: begin
					rsp_q.modifier_mask[2] <= (alt_ext < count_ext) &&
						rd_q.state[kst_pkg::HELD_BIT];
				end
			endcase
		end
	end

	assign rsp = rsp_q;

endmodule
